@@ hdl/qyae_pkg.sv @@
// Package: shared types and constants for the quaternion yaw/altitude error core.
package qyae_pkg;

  localparam int unsigned TABLE_LEN = 30;
  localparam int unsigned ANG_W = 36;   // Q30 angle with headroom for 2*atan2 and pi
  localparam int unsigned VEC_W = 44;   // CORDIC x/y width
  localparam logic signed [ANG_W-1:0] PI_Q30 = 36'sd3373259426;

  localparam logic [0:0] REG_ALT_SETPOINT = 1'b0;
  localparam logic [0:0] REG_YAW_OFFSET   = 1'b1;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_POS    = 2'd1,
    MODE_NEG    = 2'd2
  } mode_t;

  function automatic logic signed [ANG_W-1:0] atan_entry(input int unsigned i);
    logic signed [ANG_W-1:0] v;
    begin
      case (i)
        0: v = 36'sd843314856;   1: v = 36'sd497837829;   2: v = 36'sd263043836;
        3: v = 36'sd133525158;   4: v = 36'sd67021686;    5: v = 36'sd33543515;
        6: v = 36'sd16775850;    7: v = 36'sd8388437;     8: v = 36'sd4194282;
        9: v = 36'sd2097149;     10: v = 36'sd1048575;    11: v = 36'sd524287;
        12: v = 36'sd262143;     13: v = 36'sd131071;     14: v = 36'sd65535;
        15: v = 36'sd32767;      16: v = 36'sd16383;      17: v = 36'sd8191;
        18: v = 36'sd4095;       19: v = 36'sd2047;       20: v = 36'sd1023;
        21: v = 36'sd511;        22: v = 36'sd255;        23: v = 36'sd127;
        24: v = 36'sd63;         25: v = 36'sd31;         26: v = 36'sd15;
        27: v = 36'sd8;          28: v = 36'sd4;          29: v = 36'sd2;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ANG_W+1:0] v);
    begin
      if (v > 38'sd2147483647) return 32'sh7fffffff;
      else if (v < -38'sd2147483648) return 32'sh80000000;
      else return v[31:0];
    end
  endfunction

endpackage

@@ hdl/quaternion_yaw_altitude_error_core.sv @@
// Top level: pipelined quaternion yaw and altitude error core.
//
//  channel | direction | payload (low bit first)
//  in_     | slave     | altitude[31:0], quat_w, quat_x, quat_y, quat_z (16 each)
//  out_    | master    | altitude_error[31:0], yaw_error[31:0]
//  cfg_    | slave     | cfg_index 0 altitude setpoint, 1 yaw offset; cfg_data 32 bit
//
// One sample enters per cycle while out_tready does not stall the pipe. A
// result leaves through CORDIC_STEPS + 6 register stages: three stages
// of products and singular test, one pre-rotation stage, one stage per CORDIC
// micro-rotation, then rounding and error stages. rst_n clears valid bits,
// the started flag and the reference yaw. A stall on out_tready holds the
// whole pipeline in place; the first sample after reset only latches the
// reference yaw at the end of the pipe and makes no transfer.
module quaternion_yaw_altitude_error_core
  import qyae_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS  = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // altitude, quat_w, quat_x, quat_y, quat_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // altitude_error, yaw_error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned NST = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int unsigned SHR = 30 - FRACTION_BITS;

  // global advance: the pipe moves whenever the output slot is free or drains
  logic adv;
  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  logic signed [31:0] alt_setpoint_r, yaw_offset_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alt_setpoint_r <= '0;
      yaw_offset_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ALT_SETPOINT: alt_setpoint_r <= cfg_data;
        REG_YAW_OFFSET:   yaw_offset_r   <= cfg_data;
      endcase
    end
  end

  // stage 1: products
  logic               v1_r;
  logic signed [31:0] alt1_r;
  logic signed [15:0] w1_r, y1_r;
  logic signed [33:0] norm1_r, tilt1_r, cross1_r, zx1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [15:0] w, x, y, z;
      w = in_tdata[47:32]; x = in_tdata[63:48]; y = in_tdata[79:64]; z = in_tdata[95:80];
      alt1_r   <= in_tdata[31:0];
      w1_r     <= w;
      y1_r     <= y;
      // widen before multiplying so the full 32-bit products survive
      norm1_r  <= 34'(32'(w) * 32'(w)) + 34'(32'(x) * 32'(x))
                + 34'(32'(y) * 32'(y)) + 34'(32'(z) * 32'(z));
      tilt1_r  <= 34'(32'(w) * 32'(x)) + 34'(32'(y) * 32'(z));
      cross1_r <= 34'(32'(w) * 32'(z)) - 34'(32'(x) * 32'(y));
      zx1_r    <= 34'(32'(z) * 32'(z)) + 34'(32'(x) * 32'(x));
    end
  end

  // stage 2: scaled singular test terms
  logic               v2_r;
  logic signed [31:0] alt2_r;
  logic signed [15:0] w2_r, y2_r;
  logic signed [59:0] lhs2_r, rhs2_r;
  logic signed [VEC_W-1:0] num2_r, den2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      alt2_r <= alt1_r; w2_r <= w1_r; y2_r <= y1_r;
      lhs2_r <= 60'(tilt1_r) * 60'sd20000000;
      rhs2_r <= 60'(norm1_r) * 60'sd9999998;
      num2_r <= VEC_W'(cross1_r) <<< 1;
      den2_r <= (VEC_W'(1) <<< 28) - (VEC_W'(zx1_r) <<< 1);
    end
  end

  // stage 3: pick mode and CORDIC operands
  logic               v3_r;
  logic signed [31:0] alt3_r;
  mode_t              mode3_r;
  logic signed [VEC_W-1:0] x3_r, y3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      alt3_r <= alt2_r;
      if (lhs2_r > rhs2_r) begin
        mode3_r <= MODE_POS;
        x3_r <= VEC_W'(w2_r) <<< 14; y3_r <= VEC_W'(y2_r) <<< 14;
      end else if (lhs2_r < -rhs2_r) begin
        mode3_r <= MODE_NEG;
        x3_r <= VEC_W'(w2_r) <<< 14; y3_r <= VEC_W'(y2_r) <<< 14;
      end else begin
        mode3_r <= MODE_NORMAL;
        x3_r <= den2_r; y3_r <= num2_r;
      end
    end
  end

  // stage 4: pre-rotation by pi into the right half plane
  logic               vc_r  [NST+1];
  logic signed [31:0] altc_r[NST+1];
  mode_t              modec_r[NST+1];
  logic               zeroc_r[NST+1];
  logic signed [VEC_W-1:0] xc_r[NST+1], yc_r[NST+1];
  logic signed [ANG_W-1:0] zc_r[NST+1];
  always_ff @(posedge clk) begin
    if (!rst_n) vc_r[0] <= 1'b0;
    else if (adv) vc_r[0] <= v3_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      altc_r[0]  <= alt3_r;
      modec_r[0] <= mode3_r;
      zeroc_r[0] <= (x3_r == '0) && (y3_r == '0);
      if (x3_r < 0) begin
        xc_r[0] <= -x3_r; yc_r[0] <= -y3_r;
        zc_r[0] <= (y3_r >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        xc_r[0] <= x3_r; yc_r[0] <= y3_r; zc_r[0] <= '0;
      end
    end
  end

  // CORDIC micro-rotation stages
  for (genvar i = 0; i < NST; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (!rst_n) vc_r[i+1] <= 1'b0;
      else if (adv) vc_r[i+1] <= vc_r[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        altc_r[i+1]  <= altc_r[i];
        modec_r[i+1] <= modec_r[i];
        zeroc_r[i+1] <= zeroc_r[i];
        if (yc_r[i] >= 0) begin
          xc_r[i+1] <= xc_r[i] + (yc_r[i] >>> i);
          yc_r[i+1] <= yc_r[i] - (xc_r[i] >>> i);
          zc_r[i+1] <= zc_r[i] + atan_entry(i);
        end else begin
          xc_r[i+1] <= xc_r[i] - (yc_r[i] >>> i);
          yc_r[i+1] <= yc_r[i] + (xc_r[i] >>> i);
          zc_r[i+1] <= zc_r[i] - atan_entry(i);
        end
      end
    end
  end

  // rounding stage: apply singular scaling, round to the output format
  logic               v5_r;
  logic signed [31:0] alt5_r, yaw5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= vc_r[NST];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [ANG_W+1:0] a, r;
      a = zeroc_r[NST] ? '0 : (ANG_W+2)'(zc_r[NST]);
      case (modec_r[NST])
        MODE_POS: a = a <<< 1;
        MODE_NEG: a = -(a <<< 1);
        default:  a = a;
      endcase
      r = (a + ((ANG_W+2)'(1) <<< (SHR-1))) >>> SHR;
      alt5_r <= altc_r[NST];
      yaw5_r <= sat32(r);
    end
  end

  // final stage: reference capture and error outputs
  logic               started_r;
  logic signed [31:0] ref_yaw_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r  <= 1'b0;
      ref_yaw_r  <= '0;
      out_tvalid <= 1'b0;
    end else if (adv) begin
      out_tvalid <= v5_r && started_r;
      if (v5_r && !started_r) begin
        started_r <= 1'b1;
        ref_yaw_r <= yaw5_r;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata[31:0]  <= sat32((ANG_W+2)'(alt5_r) - (ANG_W+2)'(alt_setpoint_r));
      out_tdata[63:32] <= sat32((ANG_W+2)'(yaw5_r) - (ANG_W+2)'(ref_yaw_r)
                                - (ANG_W+2)'(yaw_offset_r));
    end
  end

endmodule

@@ verif/quaternion_yaw_altitude_error_core_checker.sv @@
// Checker: predicts yaw and altitude errors from observed transfers and compares results.
`timescale 1ns / 1ps
module quaternion_yaw_altitude_error_core_checker
  import qyae_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);
  localparam int STEPS = 16;
  localparam int FRAC = 16;

  // first member lands in the high half of out_tdata
  typedef struct packed {
    logic signed [31:0] yaw_err;
    logic signed [31:0] alt_err;
  } pose_err_t;

  pose_err_t err_q[$];
  logic started;
  longint ref_yaw, tgt_height, tgt_yaw;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint vector_angle(longint yy, longint xx);
    longint ang, xs, ys;
    ang = 0;
    if (xx == 0 && yy == 0) return 0;
    if (xx < 0) begin
      ang = (yy >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
      xx = -xx;
      yy = -yy;
    end
    for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
      xs = floor_shift(xx, i);
      ys = floor_shift(yy, i);
      if (yy >= 0) begin
        xx += ys; yy -= xs; ang += longint'(atan_entry(i));
      end else begin
        xx -= ys; yy += xs; ang -= longint'(atan_entry(i));
      end
    end
    return ang;
  endfunction

  function automatic longint pose_yaw(logic [95:0] d);
    longint w, x, y, z, nrm, tilt, a;
    w = longint'($signed(d[47:32]));
    x = longint'($signed(d[63:48]));
    y = longint'($signed(d[79:64]));
    z = longint'($signed(d[95:80]));
    nrm = w*w + x*x + y*y + z*z;
    tilt = w*x + y*z;
    if (64'sd20000000 * tilt > 64'sd9999998 * nrm)
      a = 2 * vector_angle(y * 16384, w * 16384);
    else if (64'sd20000000 * tilt < -64'sd9999998 * nrm)
      a = -2 * vector_angle(y * 16384, w * 16384);
    else
      a = vector_angle(2 * (w*z - x*y), (64'sd1 << 28) - 2 * (z*z + x*x));
    return clamp32(floor_shift(a + (64'sd1 << (29 - FRAC)), 30 - FRAC));
  endfunction

  assign pending_count = err_q.size();

  always @(posedge clk) begin
    pose_err_t want, got;
    longint yaw;
    if (!rst_n) begin
      started <= 1'b0;
      ref_yaw <= 0;
      tgt_height <= 0;
      tgt_yaw <= 0;
      fail_count <= 0;
      err_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ALT_SETPOINT) tgt_height <= longint'($signed(cfg_data));
        else if (cfg_index == REG_YAW_OFFSET) tgt_yaw <= longint'($signed(cfg_data));
      end
      if (in_tvalid && in_tready) begin
        yaw = pose_yaw(in_tdata);
        if (!started) begin
          started <= 1'b1;
          ref_yaw <= yaw;
        end else begin
          want.alt_err = 32'(clamp32(longint'($signed(in_tdata[31:0])) - tgt_height));
          want.yaw_err = 32'(clamp32(yaw - (ref_yaw + tgt_yaw)));
          err_q.push_back(want);
        end
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (err_q.size() == 0) begin
          $error("unexpected result %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = err_q.pop_front();
          if (got.alt_err !== want.alt_err || got.yaw_err !== want.yaw_err) begin
            if (got.alt_err !== want.alt_err)
              $error("altitude_error expected %0d actual %0d", want.alt_err, got.alt_err);
            if (got.yaw_err !== want.yaw_err)
              $error("yaw_error expected %0d actual %0d", want.yaw_err, got.yaw_err);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ verif/quaternion_yaw_altitude_error_core_tb.sv @@
// Testbench top: drives pose samples and register writes, and reports the verdict.
`timescale 1ns / 1ps
module quaternion_yaw_altitude_error_core_tb
  import qyae_pkg::*;
();

  localparam int DRAIN_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = REG_ALT_SETPOINT;
  logic [31:0] cfg_data = '0;
  int          fail_count, pending_count;
  bit          hold_off = 1'b0;   // long receiver stall to fill the pipe
  bit          stall_mode = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quaternion_yaw_altitude_error_core u_top (.*);

  quaternion_yaw_altitude_error_core_checker u_chk (.*);

  // Receiver: its own stall pattern, with stretches of full readiness.
  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else if (!stall_mode) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 63) == 0) stall_mode <= !stall_mode;
  end

  // Offer one sample and hold it until the transfer happens.
  task automatic send_pose(logic [31:0] alt, logic [15:0] w, logic [15:0] x,
                           logic [15:0] y, logic [15:0] z);
    in_tvalid <= 1'b1;
    in_tdata <= {z, y, x, w, alt};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_gap(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Wait out every expected result, then the pipe's depth in case a
  // sample with no result is still inside.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random quaternion: unit-ish with random content, near a singular pose,
  // or raw noise over the full range.
  task automatic send_random();
    logic [15:0] w, x, y, z;
    logic [31:0] alt;
    int kind;
    kind = $urandom_range(0, 9);
    alt = $urandom();
    w = 16'($urandom()); x = 16'($urandom()); y = 16'($urandom()); z = 16'($urandom());
    if (kind < 5) begin
      w = $signed(w) >>> 2; x = $signed(x) >>> 2;
      y = $signed(y) >>> 2; z = $signed(z) >>> 2;
    end else if (kind < 7) begin
      // w = x, y = z gives w*x + y*z at half the norm
      x = w; z = y;
      if ($urandom_range(0, 1)) begin
        x = -w; z = -y;
      end
      x = x + 16'($urandom_range(0, 2)) - 16'd1;
    end
    send_pose(alt, w, x, y, z);
  endtask

  initial begin
    int burst;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first sample only latches the reference yaw.
    send_pose(32'h0001_0000, 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_pose(32'h7fff_ffff, 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_pose(32'h8000_0000, 16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    send_pose(32'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);                  // zero vector
    send_pose(32'h1234, 16'sd11585, 16'sd11585, 16'sd0, 16'sd0);       // positive singular
    send_pose(32'h1234, 16'sd11585, -16'sd11585, 16'sd0, 16'sd0);      // negative singular
    send_pose(32'h1234, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);   // positive singular, y
    send_pose(32'h1234, 16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192); // negative singular, y
    send_pose(32'hffff_ffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_pose(32'h0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_pose(32'h0, 16'h8000, 16'h7fff, 16'h0, 16'h0);
    send_pose(32'h0, -16'sd16384, 16'sd0, 16'sd0, 16'sd100);           // negative w, small negative yaw
    send_pose(32'h0, -16'sd16384, 16'sd0, 16'sd0, -16'sd100);
    send_pose(32'h0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    send_pose(32'h0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    drain();

    // Extremes of both registers drive both saturations.
    write_reg(REG_ALT_SETPOINT, 32'h7fff_ffff);
    write_reg(REG_YAW_OFFSET, 32'h7fff_ffff);
    send_pose(32'h8000_0000, 16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    send_pose(32'h7fff_ffff, 16'sd0, 16'sd0, 16'sd0, -16'sd16384);
    drain();
    write_reg(REG_ALT_SETPOINT, 32'h8000_0000);
    write_reg(REG_YAW_OFFSET, 32'h8000_0000);
    send_pose(32'h7fff_ffff, -16'sd16384, 16'sd0, 16'sd0, 16'sd5);
    send_pose(32'h8000_0000, 16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    drain();

    // Random phases, each with a new register setting.
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_ALT_SETPOINT, $urandom());
      write_reg(REG_YAW_OFFSET, (phase == 5) ? 32'h0 : $urandom_range(0, 1) ?
                $urandom() : ($urandom() & 32'h0003_ffff));
      for (int n = 0; n < 300; ) begin
        burst = $urandom_range(1, 20);
        for (int k = 0; k < burst; k++) send_random();
        n += burst;
        if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
        else in_tvalid <= 1'b0;
        if (phase == 2 && n > 100 && n < 130) begin
          // Hold the receiver off long enough to back up the pipe while
          // the sender keeps offering samples.
          fork
            begin
              hold_off <= 1'b1;
              repeat (80) @(posedge clk);
              hold_off <= 1'b0;
            end
            for (int k = 0; k < 40; k++) send_random();
          join
          in_tvalid <= 1'b0;
          n += 40;
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end
endmodule

@@ sim.f @@
hdl/qyae_pkg.sv
hdl/quaternion_yaw_altitude_error_core.sv
verif/quaternion_yaw_altitude_error_core_checker.sv
verif/quaternion_yaw_altitude_error_core_tb.sv
